// File: sv/uuid7_pkg.sv
package uuid7_pkg;

  localparam int SEC_W  = 36;
  localparam int NS_W   = 30;
  localparam int SEG_W  = 16;
  localparam int RND_W  = 32;
  localparam int WORD_W = 64;

  localparam logic [3:0] UUID_VERSION = 4'd7;
  localparam logic [1:0] UUID_VARIANT = 2'd1;
  localparam logic [7:0] SEQ_MAX      = 8'hFF;
  localparam logic [7:0] SEQ_ZERO     = 8'h00;

  typedef enum logic [0:0] {
    OP_GENERATE = 1'b0,
    OP_CLEAR    = 1'b1
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [SEC_W-1:0] seconds;
    logic [NS_W-1:0]  nanoseconds;
    logic [SEG_W-1:0] segment;
    logic [RND_W-1:0] random_bits;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] uuid_high;
    logic [WORD_W-1:0] uuid_low;
    logic              ok;
  } out_item_t;

  // History update produced alongside each result
  typedef struct packed {
    logic              wr;
    logic [WORD_W-1:0] upper;
    logic [WORD_W-1:0] lower;
  } hist_upd_t;

endpackage

// File: sv/monotonic_uuid_v7_generator_core.sv
// Monotonic UUIDv7 generator core.
//
// Input channel (in_valid/in_ready/in_data) carries one request per transfer:
// a generate request with seconds, nanoseconds, segment and random word, or a
// clear request that forgets the last issued identifier.
// Output channel (out_valid/out_ready/out_data) returns exactly one result per
// request: the 128-bit identifier as two big-endian words plus an ok flag.
// A failed generate (clock went backwards, or the per-tick sequence byte is
// exhausted) returns zero words with ok low and leaves the history untouched.
//
// The result is registered, appearing in the cycle after acceptance, and one
// request per cycle is taken unless the receiver stalls; the compare against
// the stored identifier, the sequence increment and the history write all
// happen in the accept cycle; consecutive requests see each other's history.
// When the receiver stalls, the result register holds and in_ready drops; a
// new request is taken in the same cycle the held result is transferred.
// Reset (rst, synchronous) empties the result register and zeroes the history.
module monotonic_uuid_v7_generator_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  uuid7_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output uuid7_pkg::out_item_t out_data
);
  import uuid7_pkg::*;

  logic [63:0] last_upper;
  logic [63:0] last_lower;
  out_item_t   result;
  hist_upd_t   upd;
  logic        in_xfer;

  // Free the result register when it is empty or being drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  uuid7_calc u_calc (
    .item       (in_data),
    .last_upper (last_upper),
    .last_lower (last_lower),
    .result     (result),
    .upd        (upd)
  );

  // History of the last issued identifier
  always_ff @(posedge clk) begin
    if (rst) begin
      last_upper <= '0;
      last_lower <= '0;
    end else if (in_xfer && upd.wr) begin
      last_upper <= upd.upper;
      last_lower <= upd.lower;
    end
  end

  // Result register: load on input transfer, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // A clear leaves empty history behind
  assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_data.operation == OP_CLEAR |=> last_upper == '0 && last_lower == '0)
    else $error("history not cleared");

  // A failure never leaks identifier bits
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |-> out_data.uuid_high == '0 && out_data.uuid_low == '0)
    else $error("failed result carries nonzero words");

  // A successful generate is what the history now holds
  assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_data.operation == OP_GENERATE |=>
      !out_data.ok || (last_upper == out_data.uuid_high && last_lower == out_data.uuid_low))
    else $error("history does not match issued identifier");

  // Issued identifiers strictly increase over the previous history
  assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_data.operation == OP_GENERATE |=>
      !out_data.ok ||
      {out_data.uuid_high, out_data.uuid_low} > {$past(last_upper), $past(last_lower)})
    else $error("identifier not monotonic");

  // Every input transfer yields a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid)
    else $error("result missing after transfer");
`endif

endmodule

// File: sv/uuid7_calc.sv
module uuid7_calc (
  input  uuid7_pkg::in_item_t  item,
  input  logic [63:0]          last_upper,
  input  logic [63:0]          last_lower,
  output uuid7_pkg::out_item_t result,
  output uuid7_pkg::hist_upd_t upd
);
  import uuid7_pkg::*;

  logic [63:0] hi;
  logic [63:0] lo_base;
  logic [63:0] lo;
  logic [31:0] rnd_swap;
  logic [7:0]  new_top;
  logic [7:0]  old_top;
  logic [7:0]  old_seq;
  logic [7:0]  seq;
  logic        hi_eq;
  logic        backwards;
  logic        same_prefix;
  logic        exhausted;
  logic        fail;

  assign rnd_swap = {item.random_bits[7:0], item.random_bits[15:8],
                     item.random_bits[23:16], item.random_bits[31:24]};

  assign hi = {item.seconds, item.nanoseconds[29:18], UUID_VERSION,
               item.nanoseconds[17:6]};
  assign lo_base = {UUID_VARIANT, item.nanoseconds[5:0], SEQ_ZERO, item.segment, rnd_swap};

  assign new_top = lo_base[63:56];
  assign old_top = last_lower[63:56];
  assign old_seq = last_lower[55:48];

  assign hi_eq       = (last_upper == hi);
  assign backwards   = (last_upper > hi) || (hi_eq && (old_top > new_top));
  assign same_prefix = hi_eq && (old_top == new_top);

  // Count up within one tick; pin at the maximum once exhausted
  always_comb begin
    if (!same_prefix) begin
      seq = SEQ_ZERO;
    end else if (old_seq == SEQ_MAX) begin
      seq = SEQ_MAX;
    end else begin
      seq = old_seq + 8'd1;
    end
  end

  assign lo        = {lo_base[63:56], seq, lo_base[47:0]};
  assign exhausted = same_prefix && (old_seq == SEQ_MAX) && (last_lower >= lo);
  assign fail      = backwards || exhausted;

  always_comb begin
    if (item.operation == OP_CLEAR) begin
      result = '{uuid_high: '0, uuid_low: '0, ok: 1'b1};
      upd    = '{wr: 1'b1, upper: '0, lower: '0};
    end else if (fail) begin
      result = '{uuid_high: '0, uuid_low: '0, ok: 1'b0};
      upd    = '{wr: 1'b0, upper: hi, lower: lo};
    end else begin
      result = '{uuid_high: hi, uuid_low: lo, ok: 1'b1};
      upd    = '{wr: 1'b1, upper: hi, lower: lo};
    end
  end

endmodule
